// File: sv/tbt_pkg.sv
// Shared types, codes and constants for the token bucket table.
`timescale 1ns / 1ps
`default_nettype none
package tbt_pkg;

  // Default table size and the fixed field widths.
  localparam int TBT_NUM_BUCKETS = 16;
  localparam int SLOT_W          = 4;
  localparam int TOK_W           = 16;
  // Slots an index can reach; only these can ever be freed again.
  localparam int ADDR_SLOTS      = 1 << SLOT_W;

  // Operation carried by each input word.
  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_FETCH   = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_TICK    = 2'd3
  } mode_t;

  // Status reported with each result word.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_TICK = 3'b100
  } state_t;

  // One table entry as held in the bucket memory.
  typedef struct packed {
    logic [TOK_W-1:0] tokens;
    logic [TOK_W-1:0] rate;
    logic [TOK_W-1:0] burst;
  } bucket_word_t;

  // Commands from the sequencer to the slot allocator.
  typedef struct packed {
    logic              take_low;
    logic              take_hi;
    logic              drop;
    logic [SLOT_W-1:0] drop_idx;
  } alloc_cmd_t;

  // What the slot allocator offers for the next allocate.
  typedef struct packed {
    logic              free_any;
    logic [SLOT_W-1:0] free_slot;
    logic              hi_any;
    logic [SLOT_W-1:0] hi_slot;
  } alloc_stat_t;

endpackage
`default_nettype wire

// File: sv/tbt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module tbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: sv/tbt_alloc.sv
// Slot allocator: in-use flags, lowest-free search and the upper-slot fill count.
`timescale 1ns / 1ps
`default_nettype none
module tbt_alloc
  import tbt_pkg::*;
#(
  parameter int NUM_BUCKETS = TBT_NUM_BUCKETS,
  localparam int LOW_N = (NUM_BUCKETS < ADDR_SLOTS) ? NUM_BUCKETS : ADDR_SLOTS,
  localparam int HI_N  = (NUM_BUCKETS > ADDR_SLOTS) ? NUM_BUCKETS - ADDR_SLOTS : 0,
  localparam int AW    = (LOW_N > 1) ? $clog2(LOW_N) : 1,
  localparam int HI_W  = (HI_N > 0) ? $clog2(HI_N + 1) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire alloc_cmd_t       cmd,
  output alloc_stat_t           stat,
  output logic      [LOW_N-1:0] in_use
);

  logic [LOW_N-1:0] in_use_r, in_use_nxt;
  logic [HI_W-1:0]  hi_cnt_r, hi_cnt_nxt;
  logic [AW-1:0]    free_idx;
  logic             free_any;

  // Lowest free slot among those an index can reach.
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = LOW_N - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_any = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  // Slots above the index range are never freed, so they fill in order.
  always_comb begin
    stat.free_any  = free_any;
    stat.free_slot = SLOT_W'(free_idx);
    stat.hi_any    = (32'(hi_cnt_r) < HI_N);
    stat.hi_slot   = SLOT_W'(32'(hi_cnt_r) + ADDR_SLOTS);
  end

  // Apply the sequencer's take and drop commands.
  always_comb begin
    in_use_nxt = in_use_r;
    hi_cnt_nxt = hi_cnt_r;
    if (cmd.take_low) begin
      in_use_nxt[free_idx] = 1'b1;
    end
    if (cmd.drop) begin
      in_use_nxt[cmd.drop_idx[AW-1:0]] = 1'b0;
    end
    if (cmd.take_hi) begin
      hi_cnt_nxt = hi_cnt_r + HI_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      hi_cnt_r <= '0;
    end else begin
      in_use_r <= in_use_nxt;
      hi_cnt_r <= hi_cnt_nxt;
    end
  end

  assign in_use = in_use_r;

endmodule
`default_nettype wire

// File: sv/token_bucket_table.sv
// Top level: sequencer and read-modify-write datapath around the bucket memory.
// Allocate, fetch and release: no new word is taken while one executes; its result strobes
// in the cycle after the execute cycle, and a new word is taken in that same strobe cycle.
// Tick walks min(NUM_BUCKETS, 16) entries through the memory's single read port, writing
// back each entry in use while reading the next, and strobes after the last entry.
// Reset clears the in-use flags and the sequencer; the memory itself is not cleared.
// The receiver cannot stall: every result is shown for one cycle on out_valid.
`timescale 1ns / 1ps
`default_nettype none
module token_bucket_table
  import tbt_pkg::*;
#(
  parameter int NUM_BUCKETS = TBT_NUM_BUCKETS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_mode,
  input  wire logic [SLOT_W-1:0] in_bucket,
  input  wire logic [TOK_W-1:0]  in_rate,
  input  wire logic [TOK_W-1:0]  in_burst_limit,
  input  wire logic [TOK_W-1:0]  in_request,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output logic [SLOT_W-1:0]      out_slot,
  output logic [TOK_W-1:0]       out_granted
);

  localparam int LOW_N = (NUM_BUCKETS < ADDR_SLOTS) ? NUM_BUCKETS : ADDR_SLOTS;
  localparam int AW    = (LOW_N > 1) ? $clog2(LOW_N) : 1;
  localparam int WW    = $bits(bucket_word_t);

  state_t             state_r, state_nxt;
  mode_t              mode_r;
  logic [SLOT_W-1:0]  idx_r;
  logic [TOK_W-1:0]   rate_r, burst_r, req_r;
  logic               bad_r;
  logic [AW-1:0]      cnt_r, cnt_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic [TOK_W-1:0]   out_granted_r, out_granted_nxt;

  logic               accept, in_bad, tick_last;
  mode_t              in_mode_e;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  bucket_word_t       ram_wdata, rd_word;
  logic [WW-1:0]      ram_rdata;

  alloc_cmd_t         acmd;
  alloc_stat_t        astat;
  logic [LOW_N-1:0]   in_use;

  logic [TOK_W-1:0]   grant, tok_left;
  logic [TOK_W:0]     tick_sum;
  logic [TOK_W-1:0]   tick_tok;

  assign in_mode_e = mode_t'(in_mode);
  assign busy      = (state_r != S_IDLE);
  assign accept    = start && (state_r == S_IDLE);
  assign in_bad    = (32'(in_bucket) >= NUM_BUCKETS);
  assign tick_last = (cnt_r == AW'(LOW_N - 1));
  assign rd_word   = bucket_word_t'(ram_rdata);

  // Bucket memory: one entry per slot an index can reach.
  tbt_ram #(
    .WIDTH (WW),
    .DEPTH (LOW_N)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // In-use flags and free-slot search.
  tbt_alloc #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_alloc (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (acmd),
    .stat   (astat),
    .in_use (in_use)
  );

  // Fetch arithmetic: grant the smaller of request and stored tokens.
  always_comb begin
    grant    = (rd_word.tokens < req_r) ? rd_word.tokens : req_r;
    tok_left = rd_word.tokens - grant;
  end

  // Tick arithmetic: add the rate and hold the count at the burst limit.
  always_comb begin
    tick_sum = {1'b0, rd_word.tokens} + {1'b0, rd_word.rate};
    tick_tok = (tick_sum > {1'b0, rd_word.burst}) ? rd_word.burst : tick_sum[TOK_W-1:0];
  end

  // Memory read address: the addressed entry on accept (entry 0 for a tick), the next entry during a tick.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (accept) begin
      if (in_mode_e == MODE_TICK) begin
        ram_re = 1'b1;
      end else begin
        ram_re    = !in_bad;
        ram_raddr = in_bucket[AW-1:0];
      end
    end else if (state_r == S_TICK) begin
      ram_re    = !tick_last;
      ram_raddr = cnt_r + AW'(1);
    end
  end

  // Sequencer: execute step, memory writes, allocator commands and the result word.
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    ram_we          = 1'b0;
    ram_waddr       = idx_r[AW-1:0];
    ram_wdata       = rd_word;
    acmd            = '0;
    acmd.drop_idx   = idx_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    out_slot_nxt    = out_slot_r;
    out_granted_nxt = out_granted_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cnt_nxt   = '0;
          state_nxt = (in_mode_e == MODE_TICK) ? S_TICK : S_EXEC;
        end
      end
      S_EXEC: begin
        out_valid_nxt   = 1'b1;
        out_status_nxt  = ST_OK;
        out_slot_nxt    = '0;
        out_granted_nxt = '0;
        state_nxt       = S_IDLE;
        unique case (mode_r)
          MODE_ALLOC: begin
            if (astat.free_any) begin
              acmd.take_low    = 1'b1;
              ram_we           = 1'b1;
              ram_waddr        = astat.free_slot[AW-1:0];
              ram_wdata.tokens = '0;
              ram_wdata.rate   = rate_r;
              ram_wdata.burst  = burst_r;
              out_slot_nxt     = astat.free_slot;
            end else if (astat.hi_any) begin
              acmd.take_hi = 1'b1;
              out_slot_nxt = astat.hi_slot;
            end else begin
              out_status_nxt = ST_FULL;
            end
          end
          MODE_FETCH: begin
            if (bad_r || !in_use[idx_r[AW-1:0]]) begin
              out_status_nxt = ST_BAD_INDEX;
            end else if (rd_word.tokens == '0) begin
              out_status_nxt = ST_EMPTY;
            end else begin
              ram_we           = 1'b1;
              ram_wdata.tokens = tok_left;
              out_granted_nxt  = grant;
            end
          end
          MODE_RELEASE: begin
            if (bad_r) begin
              out_status_nxt = ST_BAD_INDEX;
            end else begin
              acmd.drop = 1'b1;
            end
          end
          MODE_TICK: begin
            // A tick never reaches this state; report ok to keep the arm complete.
            out_status_nxt = ST_OK;
          end
          default: begin
            out_status_nxt = ST_OK;
          end
        endcase
      end
      S_TICK: begin
        // Entry cnt_r is on the read data; write it back if the slot is in use.
        ram_waddr        = cnt_r;
        ram_wdata.tokens = tick_tok;
        ram_we           = in_use[cnt_r];
        cnt_nxt          = cnt_r + AW'(1);
        if (tick_last) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_OK;
          out_slot_nxt    = '0;
          out_granted_nxt = '0;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Captured input word, walk counter and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_mode_e;
      idx_r   <= in_bucket;
      rate_r  <= in_rate;
      burst_r <= in_burst_limit;
      req_r   <= in_request;
      bad_r   <= in_bad;
    end
    cnt_r         <= cnt_nxt;
    out_status_r  <= out_status_nxt;
    out_slot_r    <= out_slot_nxt;
    out_granted_r <= out_granted_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_slot    = out_slot_r;
  assign out_granted = out_granted_r;

endmodule
`default_nettype wire
